// ===== hw/rtl/vmc_pkg.sv =====
// vmc_pkg: shared constants for the vector magnitude clamp.
// No dependencies.
package vmc_pkg;

	localparam int COMPONENT_BITS_DEF   = 24;
	localparam int FACTOR_FRAC_BITS_DEF = 24;
	localparam int MAX_SPEED_BITS       = 23;
	localparam logic [MAX_SPEED_BITS-1:0] MAX_SPEED_RESET = 23'd8388607;

endpackage

// ===== hw/rtl/vector_magnitude_clamp.sv =====
// vector_magnitude_clamp: pipelined 3-vector length limiter.
// Depends on vmc_pkg.
//
// channel  | handshake            | payload
// cfg      | cfg_valid/cfg_ready  | max_speed
// in       | in_valid/in_ready    | vel_x vel_y vel_z bypass
// out      | out_valid/out_ready  | out_x out_y out_z was_limited
//
// One transaction per cycle while out is not stalled; out_valid rises once the input transaction
// has passed the input, square and sum registers, the one-bit-per-stage divider and square root
// chains, and the scale and output registers.
// arst_n clears all stage valid bits and restores max_speed.
// A stall on out freezes the whole pipe; in_ready drops in the same cycle.
// cfg_ready is always high.
module vector_magnitude_clamp
	import vmc_pkg::*;
#(
	parameter int COMPONENT_BITS   = COMPONENT_BITS_DEF,
	parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [MAX_SPEED_BITS-1:0] max_speed,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COMPONENT_BITS-1:0] vel_x,
	input  logic [COMPONENT_BITS-1:0] vel_y,
	input  logic [COMPONENT_BITS-1:0] vel_z,
	input  logic                      bypass,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COMPONENT_BITS-1:0] out_x,
	output logic [COMPONENT_BITS-1:0] out_y,
	output logic [COMPONENT_BITS-1:0] out_z,
	output logic                      was_limited
);

	localparam int C   = COMPONENT_BITS;
	localparam int F   = FACTOR_FRAC_BITS;
	localparam int QW  = 2 * F;
	localparam int SQW = 2 * C + 2;
	localparam int MSW = 2 * MAX_SPEED_BITS;
	localparam int DW  = (SQW > MSW) ? SQW : MSW;
	localparam int RW  = F + 3;
	localparam int NS  = 5 + QW + F;
	localparam int IM  = 3 + QW + F;

	logic [MAX_SPEED_BITS-1:0] max_speed_q;
	logic [DW-1:0]             maxsq_q;
	logic [NS-1:0]             vld_q;
	logic                      advance;

	logic [C-1:0] rx_sd [NS-1];
	logic [C-1:0] ry_sd [NS-1];
	logic [C-1:0] rz_sd [NS-1];
	logic         flg_sd [NS-1];

	logic [2*C-1:0] sq_x_s2, sq_y_s2, sq_z_s2;

	logic [DW-1:0] dr_sd [QW+1];
	logic [DW-1:0] dd_sd [QW+1];
	logic [QW-1:0] dq_sd [QW+1];

	logic [QW-1:0] srad_sd  [F+1];
	logic [RW-1:0] srem_sd  [F+1];
	logic [F-1:0]  sroot_sd [F+1];

	logic [C+F-1:0] px_sm, py_sm, pz_sm;
	logic [C-1:0]   out_x_q, out_y_q, out_z_q;
	logic           lim_q;

	function automatic logic [C-1:0] abs_c(input logic [C-1:0] v);
		abs_c = v[C-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [C-1:0] apply_sign(input logic [C-1:0] m, input logic neg);
		apply_sign = neg ? (~m + 1'b1) : m;
	endfunction

	assign cfg_ready = 1'b1;
	assign advance   = !vld_q[NS-1] || out_ready;
	assign in_ready  = advance;
	assign out_valid = vld_q[NS-1];
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign was_limited = lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RESET;
			vld_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_speed_q <= max_speed;
			if (advance)
				vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		maxsq_q <= DW'(max_speed_q) * DW'(max_speed_q);
	end

	// carried raw vector and limit flag
	always_ff @(posedge clk) begin
		if (advance) begin
			rx_sd[0]  <= vel_x;
			ry_sd[0]  <= vel_y;
			rz_sd[0]  <= vel_z;
			flg_sd[0] <= bypass;
			for (int i = 1; i < NS - 1; i++) begin
				rx_sd[i] <= rx_sd[i-1];
				ry_sd[i] <= ry_sd[i-1];
				rz_sd[i] <= rz_sd[i-1];
				if (i == 2)
					flg_sd[i] <= !flg_sd[1] &&
						(DW'(sq_x_s2) + DW'(sq_y_s2) + DW'(sq_z_s2) > maxsq_q);
				else
					flg_sd[i] <= flg_sd[i-1];
			end
		end
	end

	// squares, then sum and divider setup
	always_ff @(posedge clk) begin
		if (advance) begin
			sq_x_s2  <= abs_c(rx_sd[0]) * abs_c(rx_sd[0]);
			sq_y_s2  <= abs_c(ry_sd[0]) * abs_c(ry_sd[0]);
			sq_z_s2  <= abs_c(rz_sd[0]) * abs_c(rz_sd[0]);
			dr_sd[0] <= maxsq_q;
			dd_sd[0] <= DW'(sq_x_s2) + DW'(sq_y_s2) + DW'(sq_z_s2);
			dq_sd[0] <= '0;
		end
	end

	// restoring fraction divider, one quotient bit per stage
	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [DW:0] two_r;
		logic        ge;
		assign two_r = {dr_sd[k-1], 1'b0};
		assign ge    = two_r >= {1'b0, dd_sd[k-1]};
		always_ff @(posedge clk) begin
			if (advance) begin
				dr_sd[k] <= ge ? DW'(two_r - {1'b0, dd_sd[k-1]}) : two_r[DW-1:0];
				dd_sd[k] <= dd_sd[k-1];
				dq_sd[k] <= {dq_sd[k-1][QW-2:0], ge};
			end
		end
	end

	assign srad_sd[0]  = dq_sd[QW];
	assign srem_sd[0]  = '0;
	assign sroot_sd[0] = '0;

	// digit-by-digit square root, one root bit per stage
	for (genvar j = 1; j <= F; j++) begin : g_sqrt
		logic [RW-1:0] rem_in;
		logic [RW-1:0] trial;
		logic          ok;
		assign rem_in = {srem_sd[j-1][RW-3:0], srad_sd[j-1][QW-1:QW-2]};
		assign trial  = RW'({sroot_sd[j-1], 2'b01});
		assign ok     = rem_in >= trial;
		always_ff @(posedge clk) begin
			if (advance) begin
				srad_sd[j]  <= {srad_sd[j-1][QW-3:0], 2'b00};
				srem_sd[j]  <= ok ? (rem_in - trial) : rem_in;
				sroot_sd[j] <= {sroot_sd[j-1][F-2:0], ok};
			end
		end
	end

	// scale and output
	always_ff @(posedge clk) begin
		if (advance) begin
			px_sm <= abs_c(rx_sd[IM-1]) * sroot_sd[F];
			py_sm <= abs_c(ry_sd[IM-1]) * sroot_sd[F];
			pz_sm <= abs_c(rz_sd[IM-1]) * sroot_sd[F];
			out_x_q <= flg_sd[NS-2] ? apply_sign(px_sm[C+F-1:F], rx_sd[NS-2][C-1])
				: rx_sd[NS-2];
			out_y_q <= flg_sd[NS-2] ? apply_sign(py_sm[C+F-1:F], ry_sd[NS-2][C-1])
				: ry_sd[NS-2];
			out_z_q <= flg_sd[NS-2] ? apply_sign(pz_sm[C+F-1:F], rz_sd[NS-2][C-1])
				: rz_sd[NS-2];
			lim_q   <= flg_sd[NS-2];
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(vld_q))
		else $error("pipe moved while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(was_limited))
		else $error("output changed while stalled");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2+QW] && flg_sd[2+QW] |-> dr_sd[QW] < dd_sd[QW])
		else $error("divider remainder out of range");

endmodule
